>>> rtl/mtws_pkg.sv
// Package for the multi-task watchdog supervisor: operation codes, field widths,
// stream packing widths and reset defaults. No dependencies.

package mtws_pkg;

	localparam int OPCODE_W   = 2;
	localparam int TASK_ID_W  = 8;
	localparam int TIME_W     = 32;
	localparam int MASK_OUT_W = 32;

	// Input stream word: opcode, task_id, now_ms from bit 0 up, padded to 48 bits.
	localparam int S_TDATA_W  = 48;
	// Output stream word: status, healthy, kick, fault, starving_mask, padded to 40 bits.
	localparam int M_TDATA_W  = 40;

	localparam int          MAX_TASKS_DEF   = 32;
	localparam logic [31:0] TIMEOUT_RST     = 32'd1000;

	localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_HEARTBEAT  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_SERVICE    = 2'd3;

endpackage

>>> rtl/multi_task_watchdog_supervisor_unit.sv
// Top level of the multi-task watchdog supervisor: input register, task mask state,
// service decision and result register. Depends on mtws_pkg.
//
// Flow: an accepted transaction waits in the input register until the result register
// is free or drained, then moves into the result register, from which it can be taken.
// Throughput: one transaction per cycle while the output side keeps tready high.
// The figure is set by the single pass from the input register to the result register.
// Reset (arst_n low) clears both masks and the last-kick time and sets timeout to 1000.

module multi_task_watchdog_supervisor_unit
	import mtws_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Timeout register write port.
	input  logic                  cfg_wr_en,
	input  logic [TIME_W-1:0]     cfg_wr_data,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // opcode[1:0], task_id[9:2], now_ms[41:10]
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // status[0], healthy[1], kick[2], fault[3],
	                                         // starving_mask[35:4]
);

	// Configuration and supervisor state.
	logic [TIME_W-1:0]    timeout_q;
	logic [MAX_TASKS-1:0] registered_q;
	logic [MAX_TASKS-1:0] reported_q;
	logic [TIME_W-1:0]    last_kick_q;

	// Input stage holding one accepted transaction.
	logic                 valid_s1;
	logic [OPCODE_W-1:0]  opcode_s1;
	logic [TASK_ID_W-1:0] task_id_s1;
	logic [TIME_W-1:0]    now_s1;

	// Result stage.
	logic                  valid_s2;
	logic                  status_s2;
	logic                  healthy_s2;
	logic                  kick_s2;
	logic                  fault_s2;
	logic [MASK_OUT_W-1:0] starving_s2;

	// The input stage moves forward whenever the result register is free or drained.
	logic advance;
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Decoded operation of the item in the input stage.
	logic                  id_ok;
	logic [MAX_TASKS-1:0]  task_bit;
	logic [MAX_TASKS-1:0]  starving;
	logic [TIME_W-1:0]     elapsed;
	logic                  expired;
	logic                  status_d;
	logic                  healthy_d;
	logic                  kick_d;
	logic                  fault_d;
	logic [MASK_OUT_W-1:0] starving_d;
	logic [MAX_TASKS-1:0]  registered_d;
	logic [MAX_TASKS-1:0]  reported_d;
	logic                  kick_time_we;

	assign id_ok = task_id_s1 < TASK_ID_W'(MAX_TASKS);

	// One-hot select of the addressed task; all zero when the number is out of range.
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			task_bit[i] = (task_id_s1 == TASK_ID_W'(i));
		end
	end

	assign starving = registered_q & ~reported_q;
	// Elapsed time wraps modulo 2^32, so a clock that runs backwards looks very late.
	assign elapsed  = now_s1 - last_kick_q;
	assign expired  = elapsed >= timeout_q;

	always_comb begin
		status_d     = 1'b0;
		healthy_d    = 1'b0;
		kick_d       = 1'b0;
		fault_d      = 1'b0;
		starving_d   = '0;
		registered_d = registered_q;
		reported_d   = reported_q;
		kick_time_we = 1'b0;
		unique case (opcode_s1)
			OP_SERVICE: begin
				starving_d = MASK_OUT_W'(starving);
				if (starving == '0) begin
					// Every registered task has reported: refresh the watchdog and
					// open a new reporting window.
					kick_d       = 1'b1;
					healthy_d    = 1'b1;
					reported_d   = '0;
					kick_time_we = 1'b1;
				end else if (expired) begin
					fault_d = 1'b1;
				end else begin
					healthy_d = 1'b1;
				end
			end
			OP_REGISTER: begin
				status_d     = !id_ok;
				registered_d = registered_q | task_bit;
				reported_d   = reported_q | task_bit;
			end
			OP_UNREGISTER: begin
				status_d     = !id_ok;
				registered_d = registered_q & ~task_bit;
				reported_d   = reported_q & ~task_bit;
			end
			OP_HEARTBEAT: begin
				status_d   = !id_ok;
				reported_d = reported_q | task_bit;
			end
			default: begin
				status_d = 1'b0;
			end
		endcase
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RST;
			registered_q <= '0;
			reported_q   <= '0;
			last_kick_q  <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				registered_q <= registered_d;
				reported_q   <= reported_d;
				if (kick_time_we) begin
					last_kick_q <= now_s1;
				end
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1  <= s_tdata[OPCODE_W-1:0];
			task_id_s1 <= s_tdata[OPCODE_W +: TASK_ID_W];
			now_s1     <= s_tdata[OPCODE_W+TASK_ID_W +: TIME_W];
		end
		if (advance) begin
			status_s2   <= status_d;
			healthy_s2  <= healthy_d;
			kick_s2     <= kick_d;
			fault_s2    <= fault_d;
			starving_s2 <= starving_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(M_TDATA_W-MASK_OUT_W-4)'(0), starving_s2,
	                   fault_s2, kick_s2, healthy_s2, status_s2};

	// A kick and a fault never come from the same service call.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(kick_s2 && fault_s2))
		else $error("kick and fault raised together");

	// A kick means nothing was starving and the result is healthy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kick_s2) |-> (healthy_s2 && starving_s2 == '0))
		else $error("kick with starving tasks or unhealthy result");

	// A rejected task number never produces a service outcome.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2) |-> (!healthy_s2 && !kick_s2 && !fault_s2))
		else $error("out-of-range task with service outcome");

	// A kick opens a fresh window with an empty reported mask and the new time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kick_time_we) |=> (reported_q == '0 && last_kick_q == $past(now_s1)))
		else $error("kick did not restart the reporting window");

	// The result register only changes hands through the stream handshake.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> valid_s2)
		else $error("result dropped while stalled");

endmodule
